// ===== sv/gsct_pkg.sv =====
// gsct_pkg: types, constants and helper functions for the growing-sphere
// collision time unit. No dependencies; used by every module under sv/.
package gsct_pkg;

    localparam int DIMENSIONS = 3;
    localparam int LANE_COUNT = 3;

    typedef enum logic [1:0] {
        OUT_FOUND     = 2'd0,
        OUT_IMMEDIATE = 2'd1,
        OUT_NEVER     = 2'd2,
        OUT_OVERLAP   = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        REG_BASE_RADIUS = 2'd0,
        REG_GROWTH_RATE = 2'd1,
        REG_DET_TOL     = 2'd2,
        REG_OVERLAP_TOL = 2'd3
    } reg_index_t;

    // partial sums from one lane
    typedef struct packed {
        logic [63:0]        sq;
        logic [63:0]        vsq;
        logic signed [63:0] dot;
    } lane_sum_t;

    // result beat
    typedef struct packed {
        logic [31:0] delay;
        outcome_t    outcome;
    } result_t;

endpackage

// ===== sv/gsct_lane.sv =====
// gsct_lane: one coordinate lane, squares and product of position and velocity.
// Depends on gsct_pkg. Two register stages: products, then floor by four.
module gsct_lane (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     active,
    input  logic signed [31:0]       pos,
    input  logic signed [31:0]       vel,
    output gsct_pkg::lane_sum_t      sum
);

    logic [63:0]        pp_reg, vv_reg, sq_reg, vsq_reg;
    logic signed [63:0] pv_reg, dot_reg;

    // 32 by 32 products, zero when the lane is unused
    always_ff @(posedge aclk) begin
        if (en) begin
            pp_reg <= active ? 64'($signed(pos) * $signed(pos)) : 64'd0;
            vv_reg <= active ? 64'($signed(vel) * $signed(vel)) : 64'd0;
            pv_reg <= active ? 64'($signed(pos) * $signed(vel)) : 64'sd0;
        end
    end

    // floor by four
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg  <= pp_reg >> 2;
            vsq_reg <= vv_reg >> 2;
            dot_reg <= pv_reg >>> 2;
        end
    end

    assign sum.sq  = sq_reg;
    assign sum.vsq = vsq_reg;
    assign sum.dot = dot_reg;

endmodule

// ===== sv/gsct_merge.sv =====
// gsct_merge: combines lane sums with radius terms into A, B, C and passes the
// overlap threshold on. Depends on gsct_pkg.
module gsct_merge (
    input  logic                                             aclk,
    input  logic                                             en,
    input  gsct_pkg::lane_sum_t [gsct_pkg::LANE_COUNT-1:0]   lanes,
    input  logic [63:0]                                      rr,
    input  logic [63:0]                                      gg,
    input  logic [63:0]                                      rg,
    input  logic [63:0]                                      thr,
    output logic signed [63:0]                               a_coef,
    output logic signed [63:0]                               b_coef,
    output logic signed [63:0]                               c_coef,
    output logic [63:0]                                      thr_out
);

    logic [63:0]        sq_sum, vsq_sum;
    logic signed [63:0] dot_sum;

    always_comb begin
        sq_sum  = '0;
        vsq_sum = '0;
        dot_sum = '0;
        for (int k = 0; k < gsct_pkg::LANE_COUNT; k++) begin
            sq_sum  = sq_sum + lanes[k].sq;
            vsq_sum = vsq_sum + lanes[k].vsq;
            dot_sum = dot_sum + lanes[k].dot;
        end
    end

    // coefficient register
    always_ff @(posedge aclk) begin
        if (en) begin
            c_coef  <= $signed(sq_sum - (rr >> 8));
            a_coef  <= $signed(vsq_sum - (gg >> 16));
            b_coef  <= dot_sum - $signed(rg >> 12);
            thr_out <= thr;
        end
    end

endmodule

// ===== sv/gsct_solve.sv =====
// gsct_solve: determinant, then square root and division pipelined one bit a stage.
// Depends on gsct_pkg.
module gsct_solve (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [63:0]        a_coef,
    input  logic signed [63:0]        b_coef,
    input  logic signed [63:0]        c_coef,
    input  logic [63:0]               thr,
    input  logic [31:0]               det_tol,
    output gsct_pkg::result_t         result
);

    localparam int SQ_BITS = 63;

    // stage: magnitudes of partial products (b*b and a*c split 32x32)
    logic         ac_neg_reg;
    logic signed [63:0] a1_reg, b1_reg, c1_reg;
    logic [63:0]  thr1_reg;

    logic [63:0] b_mag, a_mag, c_mag;
    assign b_mag = b_coef[63] ? 64'(-b_coef) : 64'(b_coef);
    assign a_mag = a_coef[63] ? 64'(-a_coef) : 64'(a_coef);
    assign c_mag = c_coef[63] ? 64'(-c_coef) : 64'(c_coef);

    // three 32x32 partial products for b*b and four for a*c, registered
    logic [63:0] bp00, bp01, bp11, ap00, ap01, ap10, ap11;
    always_ff @(posedge aclk) begin
        if (en) begin
            bp00 <= b_mag[31:0] * b_mag[31:0];
            bp01 <= b_mag[31:0] * b_mag[63:32];
            bp11 <= b_mag[63:32] * b_mag[63:32];
            ap00 <= a_mag[31:0] * c_mag[31:0];
            ap01 <= a_mag[31:0] * c_mag[63:32];
            ap10 <= a_mag[63:32] * c_mag[31:0];
            ap11 <= a_mag[63:32] * c_mag[63:32];
            ac_neg_reg <= a_coef[63] ^ c_coef[63];
            a1_reg <= a_coef;
            b1_reg <= b_coef;
            c1_reg <= c_coef;
            thr1_reg <= thr;
        end
    end

    // stage: assemble determinant
    logic [127:0] bb_c, ac_c, det_c;
    always_comb begin
        bb_c = {64'd0, bp00} + ({64'd0, bp01} << 33) + ({bp11, 64'd0});
        ac_c = {64'd0, ap00} + ({64'd0, ap01} << 32) + ({64'd0, ap10} << 32)
             + {ap11, 64'd0};
        det_c = ac_neg_reg ? bb_c + ac_c : bb_c - ac_c;
    end

    logic [127:0] det2_reg;
    logic         early_reg;
    gsct_pkg::outcome_t early_out_reg;
    logic signed [63:0] a2_reg, b2_reg, c2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
            c2_reg <= c1_reg;
            // early decisions: overlap, touching, negative determinant
            if (c1_reg < -$signed(thr1_reg)) begin
                early_reg <= 1'b1;
                early_out_reg <= gsct_pkg::OUT_OVERLAP;
                det2_reg <= '0;
            end else if (c1_reg <= 0) begin
                early_reg <= 1'b1;
                early_out_reg <= b1_reg < 0 ? gsct_pkg::OUT_IMMEDIATE
                                            : gsct_pkg::OUT_NEVER;
                det2_reg <= '0;
            end else if (det_c[127]) begin
                det2_reg <= '0;
                if (128'(-det_c) < {64'd0, det_tol, 32'd0}) begin
                    early_reg <= 1'b0;
                    early_out_reg <= gsct_pkg::OUT_FOUND;
                end else begin
                    early_reg <= 1'b1;
                    early_out_reg <= gsct_pkg::OUT_NEVER;
                end
            end else begin
                early_reg <= 1'b0;
                early_out_reg <= gsct_pkg::OUT_FOUND;
                det2_reg <= det_c;
            end
        end
    end

    // square root pipeline, restoring, one bit per stage
    typedef struct packed {
        logic [127:0]       rem;
        logic [63:0]        root;
        logic               early;
        gsct_pkg::outcome_t eout;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] c;
    } sq_stage_t;

    sq_stage_t sq_pipe [SQ_BITS+1];
    assign sq_pipe[0] = '{rem: det2_reg, root: 64'd0, early: early_reg,
                          eout: early_out_reg, a: a2_reg, b: b2_reg, c: c2_reg};

    // remainder method: rem = det - root^2 kept incrementally
    for (genvar i = 0; i < SQ_BITS; i++) begin : g_sqrt
        localparam int BIT = SQ_BITS - 1 - i;
        sq_stage_t nx;
        logic [129:0] trial;
        always_comb begin
            nx = sq_pipe[i];
            // (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
            trial = (130'(sq_pipe[i].root) << (BIT + 1)) + (130'd1 << (2 * BIT));
            if ({2'b00, sq_pipe[i].rem} >= trial) begin
                nx.rem  = 128'({2'b00, sq_pipe[i].rem} - trial);
                nx.root = sq_pipe[i].root | (64'd1 << BIT);
            end
        end
        sq_stage_t st_reg;
        always_ff @(posedge aclk) begin
            if (en) st_reg <= nx;
        end
        assign sq_pipe[i+1] = st_reg;
    end

    // divide set-up
    sq_stage_t sf;
    assign sf = sq_pipe[SQ_BITS];

    typedef struct packed {
        logic [127:0]       num;
        logic [63:0]        den;
        logic [31:0]        q;
        logic               sat;
        logic               early;
        gsct_pkg::outcome_t eout;
    } dv_stage_t;

    dv_stage_t dv_in_c;
    logic [63:0] den_c, top_c;
    always_comb begin
        dv_in_c = '0;
        dv_in_c.early = sf.early;
        dv_in_c.eout  = sf.eout;
        den_c = 64'd1;
        top_c = 64'(sf.b) + sf.root;
        if (!sf.early) begin
            if (sf.b < 0) begin
                den_c = 64'(-sf.b) + sf.root;
                dv_in_c.num = {52'd0, sf.c, 12'd0};
            end else if (sf.a < 0) begin
                den_c = 64'(-sf.a);
                dv_in_c.num = {52'd0, top_c, 12'd0};
            end else begin
                dv_in_c.early = 1'b1;
                dv_in_c.eout  = gsct_pkg::OUT_NEVER;
            end
        end
        dv_in_c.den = den_c;
        dv_in_c.sat = dv_in_c.num >= {den_c, 64'd0} >> 32;
    end

    dv_stage_t dv_pipe [33];
    dv_stage_t dv0_reg;
    always_ff @(posedge aclk) begin
        if (en) dv0_reg <= dv_in_c;
    end
    assign dv_pipe[0] = dv0_reg;

    for (genvar j = 0; j < 32; j++) begin : g_div
        localparam int BIT = 31 - j;
        dv_stage_t nx;
        logic [127:0] dd;
        always_comb begin
            nx = dv_pipe[j];
            dd = {64'd0, dv_pipe[j].den} << BIT;
            if (dv_pipe[j].num >= dd) begin
                nx.num = dv_pipe[j].num - dd;
                nx.q   = dv_pipe[j].q | (32'd1 << BIT);
            end
        end
        dv_stage_t st_reg;
        always_ff @(posedge aclk) begin
            if (en) st_reg <= nx;
        end
        assign dv_pipe[j+1] = st_reg;
    end

    dv_stage_t df;
    assign df = dv_pipe[32];

    always_comb begin
        if (df.early) begin
            result.outcome = df.eout;
            result.delay   = (df.eout == gsct_pkg::OUT_NEVER) ? 32'hFFFF_FFFF : 32'd0;
        end else begin
            result.outcome = gsct_pkg::OUT_FOUND;
            result.delay   = df.sat ? 32'hFFFF_FFFF : df.q;
        end
    end

endmodule

// ===== sv/growing_sphere_collision_time_unit.sv =====
// Growing-sphere collision time unit: takes one pair per cycle while the output is
// not stalled; each result passes its pipeline stages (radius 3, lanes 2, merge 1,
// determinant 2, square root 63, divider set-up 1 and 32 bit stages). The whole
// pipeline halts while a result waits at the output. Configuration writes must
// go in only while the unit is idle; the unit itself does not enforce this.
// Depends on gsct_pkg, gsct_lane, gsct_merge and gsct_solve.
module growing_sphere_collision_time_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos x, y, z, vel x, y, z, now_time (32 bits each, low first)
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // contact_delay [31:0], outcome [33:32], zero pad to 40 bits
    output logic [39:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int LATENCY = 104;

    logic [31:0] base_radius_reg, growth_rate_reg, det_tol_reg, overlap_tol_reg;

    // configuration registers
    assign cfg_ready = aresetn;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_radius_reg <= '0;
            growth_rate_reg <= '0;
            det_tol_reg     <= '0;
            overlap_tol_reg <= '0;
        end else if (cfg_valid) begin
            unique case (gsct_pkg::reg_index_t'(cfg_index))
                gsct_pkg::REG_BASE_RADIUS: base_radius_reg <= cfg_data;
                gsct_pkg::REG_GROWTH_RATE: growth_rate_reg <= cfg_data;
                gsct_pkg::REG_DET_TOL:     det_tol_reg     <= cfg_data;
                gsct_pkg::REG_OVERLAP_TOL: overlap_tol_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advances when the output slot is free or being emptied
    logic en;
    logic [LATENCY-1:0] vld_reg;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en && aresetn;
    assign m_tvalid = vld_reg[LATENCY-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en)  vld_reg <= {vld_reg[LATENCY-2:0], s_tvalid};
    end

    // radius stage 1: time times rate
    logic [63:0] tg_reg;
    logic [31:0] p1_reg [6];
    always_ff @(posedge aclk) begin
        if (en) begin
            tg_reg <= s_tdata[223:192] * growth_rate_reg;
            for (int k = 0; k < 6; k++) p1_reg[k] <= s_tdata[32*k +: 32];
        end
    end

    // radius stage 2: add base and saturate
    logic [32:0] rsum;
    logic        r_sat;
    logic [31:0] r2_reg;
    logic [31:0] p2_reg [6];
    assign rsum  = {1'b0, base_radius_reg} + {1'b0, tg_reg[47:16]};
    assign r_sat = rsum[32] || (tg_reg[63:48] != 16'd0);
    always_ff @(posedge aclk) begin
        if (en) begin
            r2_reg <= r_sat ? 32'hFFFF_FFFF : rsum[31:0];
            p2_reg <= p1_reg;
        end
    end

    // radius stage 3: radius products
    logic [63:0] rr_reg, gg_reg, rg_reg, ro_reg;
    logic [31:0] p3_reg [6];
    always_ff @(posedge aclk) begin
        if (en) begin
            rr_reg <= r2_reg * r2_reg;
            gg_reg <= growth_rate_reg * growth_rate_reg;
            rg_reg <= r2_reg * growth_rate_reg;
            ro_reg <= overlap_tol_reg * r2_reg;
            p3_reg <= p2_reg;
        end
    end

    // delay radius terms to match the two lane stages
    logic [63:0] rr_d [2], gg_d [2], rg_d [2], thr_d [2];
    always_ff @(posedge aclk) begin
        if (en) begin
            rr_d[0] <= rr_reg;  rr_d[1] <= rr_d[0];
            gg_d[0] <= gg_reg;  gg_d[1] <= gg_d[0];
            rg_d[0] <= rg_reg;  rg_d[1] <= rg_d[0];
            thr_d[0] <= ro_reg >> 41; thr_d[1] <= thr_d[0];
        end
    end

    // coordinate lanes
    gsct_pkg::lane_sum_t [gsct_pkg::LANE_COUNT-1:0] lane_sums;
    for (genvar k = 0; k < gsct_pkg::LANE_COUNT; k++) begin : g_lane
        gsct_lane u_lane (
            .aclk   (aclk),
            .en     (en),
            .active (k < gsct_pkg::DIMENSIONS),
            .pos    ($signed(p3_reg[k])),
            .vel    ($signed(p3_reg[k+3])),
            .sum    (lane_sums[k])
        );
    end

    logic signed [63:0] a_coef, b_coef, c_coef;
    logic [63:0] thr;
    gsct_merge u_merge (
        .aclk    (aclk),
        .en      (en),
        .lanes   (lane_sums),
        .rr      (rr_d[1]),
        .gg      (gg_d[1]),
        .rg      (rg_d[1]),
        .thr     (thr_d[1]),
        .a_coef  (a_coef),
        .b_coef  (b_coef),
        .c_coef  (c_coef),
        .thr_out (thr)
    );

    gsct_pkg::result_t res;
    gsct_solve u_solve (
        .aclk    (aclk),
        .en      (en),
        .a_coef  (a_coef),
        .b_coef  (b_coef),
        .c_coef  (c_coef),
        .thr     (thr),
        .det_tol (det_tol_reg),
        .result  (res)
    );

    assign m_tdata = {6'd0, res.outcome, res.delay};

    // assertions
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");
    a_early_delay: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] == gsct_pkg::OUT_OVERLAP
                     || m_tdata[33:32] == gsct_pkg::OUT_IMMEDIATE)
        |-> m_tdata[31:0] == 32'd0)
        else $error("non-zero delay on immediate or overlap");

endmodule
